### src/lzss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_pkg
// Shared types and codes for the LZSS stream decompressor.
// ----------------------------------------------------------------------------
package lzss_pkg;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_BYTE  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPEND,
        ST_PARSE,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic tbl_wr;
        logic start;
        logic tbl_rd;
        logic append;
        logic emit_lit;
        logic take_match;
        logic hist_rd;
        logic emit_copy;
        logic clear_pend;
        logic flush;
    } t_dp_cmd;

    typedef struct packed {
        logic rem_zero;
        logic rem_one;
        logic lit_ready;
        logic match_ready;
        logic copy_last;
        logic hold_v;
        logic out_free;
        logic can_stage;
    } t_dp_stat;

endpackage

### src/lzss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_ctrl
// Controller: accepts items and sequences token parsing and match copies.
// ----------------------------------------------------------------------------
module lzss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic [1:0]        i_s_op,
    input  lzss_pkg::t_dp_stat i_stat,
    output logic              o_s_tready,
    output lzss_pkg::t_dp_cmd o_cmd
);
    import lzss_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_s_op)
                        OP_LOAD: begin
                            o_cmd.tbl_wr = 1'b1;
                        end
                        OP_START: begin
                            o_cmd.start = 1'b1;
                        end
                        OP_BYTE: begin
                            if (!i_stat.rem_zero) begin
                                o_cmd.tbl_rd = 1'b1;
                                n_state      = ST_APPEND;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = ST_PARSE;
            end
            ST_PARSE: begin
                if (i_stat.rem_zero) begin
                    o_cmd.clear_pend = 1'b1;
                    n_state          = ST_FLUSH;
                end else if (i_stat.lit_ready) begin
                    if (i_stat.can_stage) begin
                        o_cmd.emit_lit = 1'b1;
                    end
                end else if (i_stat.match_ready) begin
                    o_cmd.take_match = 1'b1;
                    n_state          = ST_COPY_RD;
                end else begin
                    n_state = ST_FLUSH;
                end
            end
            ST_COPY_RD: begin
                o_cmd.hist_rd = 1'b1;
                n_state       = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                if (i_stat.can_stage) begin
                    o_cmd.emit_copy = 1'b1;
                    if (i_stat.copy_last || i_stat.rem_one) begin
                        n_state = ST_PARSE;
                    end else begin
                        n_state = ST_COPY_RD;
                    end
                end
            end
            ST_FLUSH: begin
                if (!i_stat.hold_v) begin
                    n_state = ST_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### src/lzss_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_dp
// Datapath: substitution table, bit buffer, history window, output staging.
// ----------------------------------------------------------------------------
module lzss_dp #(
    parameter int OFFSET_BITS = 8,
    parameter int COUNT_BITS  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lzss_pkg::t_dp_cmd i_cmd,
    input  logic [47:0]       i_s_tdata,
    input  logic              i_m_tready,
    output lzss_pkg::t_dp_stat o_stat,
    output logic              o_m_tvalid,
    output logic [7:0]        o_m_tdata,
    output logic              o_m_tlast,
    output logic              o_m_tuser
);
    import lzss_pkg::*;

    localparam int WIN_SIZE   = 1 << OFFSET_BITS;
    localparam int START_I    = WIN_SIZE - (1 << COUNT_BITS) - 1;
    localparam logic [OFFSET_BITS-1:0] START_POS = START_I[OFFSET_BITS-1:0];
    localparam int MATCH_BITS = 1 + OFFSET_BITS + COUNT_BITS;
    localparam int PB_W       = OFFSET_BITS + COUNT_BITS + 8;
    localparam int PC_W       = $clog2(PB_W + 1);
    localparam int FILL_W     = OFFSET_BITS + 1;
    localparam int CL_W       = COUNT_BITS + 1;

    logic [7:0]             w_byte_value;
    logic [7:0]             w_table_index;
    logic [31:0]            w_output_length;

    logic [7:0]             r_tbl_mem [256];
    logic [255:0]           r_tbl_valid;
    logic [7:0]             r_tbl_q;
    logic                   r_tbl_qv;
    logic [7:0]             r_tbl_qi;

    logic [7:0]             r_hist_mem [WIN_SIZE];
    logic [7:0]             r_hist_raw;
    logic                   r_hist_ok;

    logic [PB_W-1:0]        r_pend;
    logic [PC_W-1:0]        r_pcnt;
    logic [31:0]            r_rem;
    logic [OFFSET_BITS-1:0] r_wp;
    logic [FILL_W-1:0]      r_fill;
    logic [OFFSET_BITS-1:0] r_cp_addr;
    logic [COUNT_BITS:0]    r_cp_left;

    logic                   r_hold_v;
    logic [7:0]             r_hold_b;
    logic                   r_out_v;
    logic [7:0]             r_out_b;
    logic                   r_out_last;
    logic                   r_out_done;

    logic [PB_W-1:0]        w_flag_vec;
    logic [PB_W-1:0]        w_lit_vec;
    logic [PB_W-1:0]        w_match_vec;
    logic                   w_flag;
    logic [7:0]             w_sub_byte;
    logic [OFFSET_BITS-1:0] w_dist;
    logic                   w_stage;
    logic [7:0]             w_stage_b;
    logic                   w_out_free;

    assign w_byte_value    = i_s_tdata[7:0];
    assign w_table_index   = i_s_tdata[15:8];
    assign w_output_length = i_s_tdata[47:16];

    assign w_flag_vec  = r_pend >> (r_pcnt - PC_W'(1));
    assign w_lit_vec   = r_pend >> (r_pcnt - PC_W'(9));
    assign w_match_vec = r_pend >> (r_pcnt - PC_W'(MATCH_BITS));
    assign w_flag      = w_flag_vec[0];
    assign w_sub_byte  = r_tbl_qv ? r_tbl_q : r_tbl_qi;
    assign w_dist      = r_cp_addr - START_POS;
    assign w_stage     = i_cmd.emit_lit || i_cmd.emit_copy;
    assign w_stage_b   = i_cmd.emit_lit ? w_lit_vec[7:0] : (r_hist_ok ? r_hist_raw : 8'd0);
    assign w_out_free  = !r_out_v || i_m_tready;

    assign o_stat.rem_zero    = (r_rem == 32'd0);
    assign o_stat.rem_one     = (r_rem == 32'd1);
    assign o_stat.lit_ready   = w_flag && (r_pcnt >= PC_W'(9));
    assign o_stat.match_ready = !w_flag && (r_pcnt >= PC_W'(MATCH_BITS));
    assign o_stat.copy_last   = (r_cp_left == '0);
    assign o_stat.hold_v      = r_hold_v;
    assign o_stat.out_free    = w_out_free;
    assign o_stat.can_stage   = !r_hold_v || w_out_free;

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_b;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_done;

    // substitution table, identity until an entry is loaded
    always_ff @(posedge i_clk) begin
        if (i_cmd.tbl_wr) begin
            r_tbl_mem[w_table_index] <= w_byte_value;
        end
        if (i_cmd.tbl_rd) begin
            r_tbl_q  <= r_tbl_mem[w_byte_value];
            r_tbl_qi <= w_byte_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl_valid <= '0;
            r_tbl_qv    <= 1'b0;
        end else begin
            if (i_cmd.tbl_wr) begin
                r_tbl_valid[w_table_index] <= 1'b1;
            end
            if (i_cmd.tbl_rd) begin
                r_tbl_qv <= r_tbl_valid[w_byte_value];
            end
        end
    end

    // history window; entries beyond the fill count read as zero
    always_ff @(posedge i_clk) begin
        if (w_stage) begin
            r_hist_mem[r_wp] <= w_stage_b;
        end
        if (i_cmd.hist_rd) begin
            r_hist_raw <= r_hist_mem[r_cp_addr];
            r_hist_ok  <= ({1'b0, w_dist} < r_fill);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_pend <= {r_pend[PB_W-9:0], w_sub_byte};
        end
        if (i_cmd.take_match) begin
            r_cp_addr <= w_match_vec[COUNT_BITS +: OFFSET_BITS];
        end else if (i_cmd.emit_copy) begin
            r_cp_addr <= r_cp_addr + OFFSET_BITS'(1);
        end
        if (w_stage) begin
            r_hold_b <= w_stage_b;
        end
        if (i_cmd.flush || (w_stage && r_hold_v)) begin
            r_out_b <= r_hold_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt     <= '0;
            r_rem      <= '0;
            r_wp       <= START_POS;
            r_fill     <= '0;
            r_cp_left  <= '0;
            r_hold_v   <= 1'b0;
            r_out_v    <= 1'b0;
            r_out_last <= 1'b0;
            r_out_done <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_pcnt <= '0;
                r_rem  <= w_output_length;
                r_wp   <= START_POS;
                r_fill <= '0;
            end else begin
                if (i_cmd.clear_pend) begin
                    r_pcnt <= '0;
                end else if (i_cmd.append) begin
                    r_pcnt <= r_pcnt + PC_W'(8);
                end else if (i_cmd.emit_lit) begin
                    r_pcnt <= r_pcnt - PC_W'(9);
                end else if (i_cmd.take_match) begin
                    r_pcnt <= r_pcnt - PC_W'(MATCH_BITS);
                end
                if (w_stage) begin
                    r_rem <= r_rem - 32'd1;
                    r_wp  <= r_wp + OFFSET_BITS'(1);
                    if (r_fill != FILL_W'(WIN_SIZE)) begin
                        r_fill <= r_fill + FILL_W'(1);
                    end
                end
            end

            if (i_cmd.take_match) begin
                r_cp_left <= {1'b0, w_match_vec[COUNT_BITS-1:0]} + CL_W'(1);
            end else if (i_cmd.emit_copy) begin
                r_cp_left <= r_cp_left - CL_W'(1);
            end

            if (i_cmd.flush) begin
                r_hold_v <= 1'b0;
            end else if (w_stage) begin
                r_hold_v <= 1'b1;
            end

            if (i_cmd.flush) begin
                r_out_v    <= 1'b1;
                r_out_last <= 1'b1;
                r_out_done <= (r_rem == 32'd0);
            end else if (w_stage && r_hold_v) begin
                r_out_v    <= 1'b1;
                r_out_last <= 1'b0;
                r_out_done <= 1'b0;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

endmodule

### src/lzss_stream_decompressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_stream_decompressor
// LZSS decoder with a loadable byte substitution table and a circular
// history window, emitting one decompressed byte per output transaction.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A table load or a stream start leaves the
// controller idle. A compressed byte goes through the table lookup and bit
// append, then each literal, each match token to decode and each copied
// byte (registered read of the single-port history window, then write-back),
// and closes the transaction with a last parse pass that finds no complete
// token, then the flush of the staged byte. While both the staging and
// output registers are full, a receiver that holds off stalls the decoder.
// Results of one item trail by one byte in a staging register so the final
// one can carry tlast; tuser marks the byte that reaches the stream length.
// The history window is tracked with a fill count, so a start needs no
// clearing pass.
module lzss_stream_decompressor #(
    parameter int OFFSET_BITS = 8,
    parameter int COUNT_BITS  = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // byte_value, table_index, output_length
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast,
    output logic        m_tuser    // stream_done
);
    import lzss_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    lzss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_op     (s_tuser),
        .i_stat     (w_stat),
        .o_s_tready (s_tready),
        .o_cmd      (w_cmd)
    );

    lzss_dp #(
        .OFFSET_BITS (OFFSET_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_s_tdata  (s_tdata),
        .i_m_tready (m_tready),
        .o_stat     (w_stat),
        .o_m_tvalid (m_tvalid),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

endmodule

### sim/lzss_stream_decompressor_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_stream_decompressor_test
// Drives table loads, stream starts and compressed bytes into the decoder,
// mostly as well-formed token streams with random content, some noise, and
// random stalls on both sides. A cycle-level-free behavioral decoder in the
// testbench predicts every output byte, its tlast and its tuser, and the
// monitor checks each output transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module lzss_stream_decompressor_test;

    import lzss_pkg::*;

    localparam logic [1:0] OP_NONE      = 2'd3;
    localparam int         START_PTR    = 239;
    localparam int         WIN_MASK     = 255;
    localparam int         MATCH_LEN    = 13;
    localparam int         N_ITEMS      = 500;
    localparam int         LIMIT_CYCLES = 1000000;
    localparam int         TAIL_CYCLES  = 100;
    localparam int         HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  bv;
        logic [7:0]  idx;
        logic [31:0] len;
        logic        drain;
    } t_item;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
    } t_result;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // byte_value, table_index, output_length
    logic [1:0]  s_tuser  = '0;   // operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // out_byte
    logic        m_tlast;
    logic        m_tuser;         // stream_done

    // stimulus side
    t_item       item_q[$];
    logic [7:0]  gen_map [256];
    logic [7:0]  gen_acc;
    int          gen_nbits;
    int          n_made;

    // decoder model
    logic [7:0]  sub_map [256];
    logic [7:0]  hist_win [256];
    int          wr_ptr;
    logic [63:0] bit_buf;
    int          bit_cnt;
    logic [31:0] bytes_left;
    t_result     decoded_q[$];

    // handshake bookkeeping
    t_item       cur_item;
    int          n_sent    = 0;
    int          n_in_acc  = 0;
    int          n_out_acc = 0;
    int          out_seen  = 0;
    int          in_gap    = 0;
    int          out_gap   = 0;
    bit          send_quiet = 1'b0;
    bit          recv_quiet = 1'b0;
    bit          long_hold  = 1'b0;
    int          cycle_cnt  = 0;
    int          err_cnt    = 0;

    lzss_stream_decompressor DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic int draw_gap(input bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 19));
    endfunction

    // ------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------
    task automatic emit_byte(input logic [7:0] c);
        t_result r;
        r.data = c;
        r.last = 1'b0;
        r.done = 1'b0;
        decoded_q.push_back(r);
        hist_win[8'(wr_ptr)] = c;
        wr_ptr = (wr_ptr + 1) & WIN_MASK;
        bytes_left = bytes_left - 32'd1;
    endtask

    task automatic decode_item(input t_item it);
        logic [63:0] tmp;
        int          pos;
        int          cnt;
        int          k;
        int          n0;
        bit          stalled;
        t_result     r;
        case (it.op)
            OP_LOAD: sub_map[it.idx] = it.bv;
            OP_START: begin
                for (k = 0; k < 256; k++) hist_win[8'(k)] = 8'h00;
                wr_ptr     = START_PTR;
                bit_buf    = '0;
                bit_cnt    = 0;
                bytes_left = it.len;
            end
            OP_BYTE: begin
                if (bytes_left != 0) begin
                    n0      = decoded_q.size();
                    bit_buf = {bit_buf[55:0], sub_map[it.bv]};
                    bit_cnt = bit_cnt + 8;
                    stalled = 1'b0;
                    while (!stalled && bytes_left != 0 && bit_cnt >= 1) begin
                        tmp = bit_buf >> (bit_cnt - 1);
                        if (tmp[0]) begin
                            if (bit_cnt < 9) begin
                                stalled = 1'b1;
                            end else begin
                                tmp = bit_buf >> (bit_cnt - 9);
                                bit_cnt = bit_cnt - 9;
                                emit_byte(tmp[7:0]);
                            end
                        end else if (bit_cnt < MATCH_LEN) begin
                            stalled = 1'b1;
                        end else begin
                            tmp = bit_buf >> (bit_cnt - 9);
                            pos = int'(tmp[7:0]);
                            tmp = bit_buf >> (bit_cnt - MATCH_LEN);
                            cnt = int'(tmp[3:0]);
                            bit_cnt = bit_cnt - MATCH_LEN;
                            // copy byte by byte so overlapping copies repeat
                            for (k = 0; k <= cnt + 1 && bytes_left != 0; k++) begin
                                emit_byte(hist_win[8'(pos + k)]);
                            end
                        end
                    end
                    if (bytes_left == 0) begin
                        bit_buf = '0;
                        bit_cnt = 0;
                    end
                    if (decoded_q.size() > n0) begin
                        r = decoded_q.pop_back();
                        r.last = 1'b1;
                        r.done = (bytes_left == 0);
                        decoded_q.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    task automatic push_item(input logic [1:0] op, input logic [7:0] bv,
                             input logic [7:0] idx, input logic [31:0] len);
        t_item it;
        it.op    = op;
        it.bv    = bv;
        it.idx   = idx;
        it.len   = len;
        it.drain = 1'b0;
        if (op == OP_LOAD) gen_map[idx] = bv;
        item_q.push_back(it);
        n_made++;
    endtask

    task automatic push_drain();
        t_item it;
        it       = '0;
        it.drain = 1'b1;
        item_q.push_back(it);
    endtask

    // pick the raw byte that the current table turns into the wanted code
    task automatic push_code(input logic [7:0] code);
        logic [7:0] b;
        int         k;
        b = code;
        for (k = 0; k < 256; k++) if (gen_map[8'(k)] == code) b = 8'(k);
        push_item(OP_BYTE, b, 8'($urandom), $urandom);
    endtask

    task automatic put_bits(input logic [15:0] v, input int n);
        int          i;
        logic [15:0] sh;
        for (i = n - 1; i >= 0; i--) begin
            sh        = v >> i;
            gen_acc   = {gen_acc[6:0], sh[0]};
            gen_nbits = gen_nbits + 1;
            if (gen_nbits == 8) begin
                push_code(gen_acc);
                gen_nbits = 0;
            end
        end
    endtask

    task automatic flush_bits();
        if (gen_nbits != 0) put_bits(16'($urandom), 8 - gen_nbits);
    endtask

    // swap two table entries so the table stays a permutation
    task automatic map_swap();
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] va;
        a  = 8'($urandom);
        b  = 8'($urandom);
        va = gen_map[a];
        push_item(OP_LOAD, gen_map[b], a, $urandom);
        push_item(OP_LOAD, va, b, $urandom);
    endtask

    task automatic send_stream(input int ntok);
        bit          tok_lit[$];
        logic [7:0]  tok_val[$];
        logic [3:0]  tok_cnt[$];
        int          total;
        int          k;
        int          mode;
        int          cnt;
        int          wp;
        logic [7:0]  lit;
        logic [31:0] len;
        total = 0;
        for (k = 0; k < ntok; k++) begin
            wp = (START_PTR + total) & WIN_MASK;
            if ($urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 5))
                    0:       lit = 8'h00;
                    1:       lit = 8'hFF;
                    default: lit = 8'($urandom);
                endcase
                tok_lit.push_back(1'b1);
                tok_val.push_back(lit);
                tok_cnt.push_back(4'd0);
                total = total + 1;
            end else begin
                cnt = int'($urandom_range(0, 15));
                tok_lit.push_back(1'b0);
                if ($urandom_range(0, 3) == 0) tok_val.push_back(8'($urandom));
                else tok_val.push_back(8'(wp - int'($urandom_range(1, 20))));
                tok_cnt.push_back(4'(cnt));
                total = total + cnt + 2;
            end
        end
        mode = int'($urandom_range(0, 9));
        if (mode <= 5) len = 32'(total);
        else if (mode <= 7) len = $urandom_range(1, total);
        else if (mode == 8) len = 32'(total) + $urandom_range(1, 30);
        else len = $urandom;
        gen_nbits = 0;
        push_item(OP_START, 8'($urandom), 8'($urandom), len);
        for (k = 0; k < ntok; k++) begin
            if ($urandom_range(0, 15) == 0) map_swap();
            if (tok_lit[k]) put_bits({7'd0, 1'b1, tok_val[k]}, 9);
            else put_bits({3'd0, 1'b0, tok_val[k], tok_cnt[k]}, MATCH_LEN);
        end
        flush_bits();
        if ($urandom_range(0, 3) == 0) begin
            push_item(OP_BYTE, 8'($urandom), 8'($urandom), $urandom);
        end
    endtask

    task automatic send_noise();
        int k;
        for (k = int'($urandom_range(1, 4)); k > 0; k--) begin
            case ($urandom_range(0, 3))
                0: map_swap();
                1: push_item(OP_NONE, 8'($urandom), 8'($urandom), $urandom);
                2: push_item(OP_BYTE, 8'($urandom), 8'($urandom), $urandom);
                default: push_item(OP_START, 8'($urandom), 8'($urandom),
                                   $urandom_range(0, 40));
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : run_test
        int k;
        int next_drain;
        for (k = 0; k < 256; k++) begin
            sub_map[8'(k)]  = 8'(k);
            gen_map[8'(k)]  = 8'(k);
            hist_win[8'(k)] = 8'h00;
        end
        wr_ptr     = START_PTR;
        bit_buf    = '0;
        bit_cnt    = 0;
        bytes_left = '0;
        gen_acc    = '0;
        gen_nbits  = 0;
        n_made     = 0;

        // directed: idle bytes, unused code, table extremes, zero length
        push_item(OP_BYTE, 8'hFF, 8'h00, 32'h0);
        push_item(OP_NONE, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        push_item(OP_LOAD, 8'h00, 8'hFF, 32'hFFFF_FFFF);
        push_item(OP_LOAD, 8'hFF, 8'h00, 32'h0);
        push_item(OP_START, 8'h00, 8'h00, 32'h0);
        push_item(OP_BYTE, 8'h80, 8'h00, 32'h0);
        // literals, overlapping full copy, copy that stops at the length
        push_item(OP_START, 8'hFF, 8'hFF, 32'd30);
        put_bits({7'd0, 1'b1, 8'h00}, 9);
        put_bits({7'd0, 1'b1, 8'hFF}, 9);
        put_bits({7'd0, 1'b1, 8'hA5}, 9);
        put_bits({3'd0, 1'b0, 8'd239, 4'd15}, MATCH_LEN);
        put_bits({3'd0, 1'b0, 8'd0, 4'd0}, MATCH_LEN);
        put_bits({3'd0, 1'b0, 8'd250, 4'd15}, MATCH_LEN);
        flush_bits();
        push_item(OP_BYTE, 8'h7F, 8'h00, 32'h0);
        // longest length, left unfinished
        push_item(OP_START, 8'h00, 8'h00, 32'hFFFF_FFFF);
        gen_nbits = 0;
        put_bits({7'd0, 1'b1, 8'h5A}, 9);
        put_bits({3'd0, 1'b0, 8'd255, 4'd15}, MATCH_LEN);
        flush_bits();
        push_drain();

        next_drain = n_made + 150;
        while (n_made < N_ITEMS) begin
            if ($urandom_range(0, 9) < 8) send_stream(int'($urandom_range(1, 12)));
            else send_noise();
            if (n_made >= next_drain) begin
                push_drain();
                next_drain = next_drain + 150;
            end
        end

        while (item_q.size() > 0 || n_in_acc != n_sent) @(posedge i_clk);
        while (decoded_q.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && decoded_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // long receiver hold while results are due, so the input backs up
    initial begin : hold_output
        while (n_in_acc < 150 || decoded_q.size() == 0) @(posedge i_clk);
        long_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold = 1'b0;
    end

    // ------------------------------------------------------------------
    // input driver
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_input
        t_item nxt;
        logic  v_next;
        if (i_rst_n) begin
            v_next = (n_in_acc != n_sent);
            if (!v_next) begin
                if (long_hold) in_gap = 0;
                if (in_gap > 0) begin
                    in_gap = in_gap - 1;
                end else if (item_q.size() > 0) begin
                    if (item_q[0].drain) begin
                        if (decoded_q.size() == 0) nxt = item_q.pop_front();
                    end else begin
                        nxt      = item_q.pop_front();
                        cur_item = nxt;
                        s_tdata  <= {nxt.len, nxt.idx, nxt.bv};
                        s_tuser  <= nxt.op;
                        v_next   = 1'b1;
                        n_sent   = n_sent + 1;
                        if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
                        in_gap = draw_gap(send_quiet);
                    end
                end
            end
            s_tvalid <= v_next;
        end
    end

    // ------------------------------------------------------------------
    // output ready
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_ready
        if (i_rst_n) begin
            if (n_out_acc != out_seen) begin
                out_seen = n_out_acc;
                if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
                out_gap = draw_gap(recv_quiet);
            end
            if (long_hold) begin
                m_tready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap = out_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor and checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_output
        t_result want;
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                decode_item(cur_item);
                n_in_acc = n_in_acc + 1;
            end
            if (m_tvalid && m_tready) begin
                n_out_acc = n_out_acc + 1;
                if (decoded_q.size() == 0) begin
                    err_cnt = err_cnt + 1;
                    if (err_cnt <= 10) begin
                        $display("unexpected output %0d: byte %h last %b done %b",
                                 n_out_acc, m_tdata, m_tlast, m_tuser);
                    end
                end else begin
                    want = decoded_q.pop_front();
                    if (m_tdata !== want.data || m_tlast !== want.last ||
                        m_tuser !== want.done) begin
                        err_cnt = err_cnt + 1;
                        if (err_cnt <= 10) begin
                            $display({"mismatch at output %0d: expected byte %h last %b ",
                                      "done %b, got byte %h last %b done %b"},
                                     n_out_acc, want.data, want.last, want.done,
                                     m_tdata, m_tlast, m_tuser);
                        end
                    end
                end
            end
        end
    end

endmodule

### filelist.f
src/lzss_pkg.sv
src/lzss_ctrl.sv
src/lzss_dp.sv
src/lzss_stream_decompressor.sv
sim/lzss_stream_decompressor_test.sv
